[sv/window_sum_threshold_counter_core_defines.svh]
// Assertion helpers shared by the window sum threshold counter.
`ifndef WINDOW_SUM_THRESHOLD_COUNTER_CORE_DEFINES_SVH
`define WINDOW_SUM_THRESHOLD_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define WSTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define WSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wstc_pkg.sv]
package wstc_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_BITS     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_BITS     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS     = 24;
  localparam int COUNT_BITS   = 32;
  localparam int CFG_LEN_BITS = 9;
  localparam int CFG_THR_BITS = 16;
  localparam int THR_LEN_BITS = CFG_THR_BITS + LEN_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WINDOW_LEN = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_THRESHOLD  = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic                shift;
    logic [IDX_BITS-1:0] len_m1;
  } wstc_chain_ctl_t;

  function automatic logic [LEN_BITS-1:0] eff_len(input logic [CFG_LEN_BITS-1:0] w);
    int v;
    v = int'(w);
    if (v == 0) begin
      v = 1;
    end else if (v > WINDOW_MAX) begin
      v = WINDOW_MAX;
    end
    return LEN_BITS'(v);
  endfunction

endpackage

[sv/window_sum_threshold_counter_core.sv]
// Sliding-window sum threshold counter.
// Samples enter on the in_ stream, one transaction per sample, with the
// first-of-sequence flag in in_tuser; a set flag clears the sum, the fill
// level and the match count before that sample is taken in.
// Every input transaction yields exactly one output transaction carrying
// window_full, window_meets and the saturating match count.
// The result is registered and sits in the output register in the cycle
// after the input transaction. Throughput is one sample per cycle unless
// the output or a cfg_ write stalls it; the sample history is a row of
// shift cells and the sample leaving the window is picked by a registered
// tap tree, so one add, one subtract and one compare against threshold
// times length finish in the cycle of acceptance. A cfg_ write holds off
// in_tready in the next cycle while tap tree and threshold product reload.
// Reset sets window_len to 1 and threshold to 0 and clears the sequence
// state. The sample cells are not cleared; only samples of the current
// sequence are ever subtracted.
// When the receiver stalls, the result stays in the output register and
// in_tready stays low until out_tready takes it.
module window_sum_threshold_counter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wstc_pkg::IN_DATA_BITS-1:0]    in_tdata,   // [15:0] sample
  input  logic                                 in_tuser,   // [0] first
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wstc_pkg::OUT_DATA_BITS-1:0]   out_tdata,  // [0] window_full,
                                                           // [1] window_meets,
                                                           // [33:2] match_count
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wstc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wstc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wstc_pkg::*;

  `include "window_sum_threshold_counter_core_defines.svh"

  logic [CFG_LEN_BITS-1:0] window_len_r;
  logic [CFG_THR_BITS-1:0] threshold_r;
  logic [THR_LEN_BITS-1:0] thr_len_r;
  logic                    cfg_hold_r;
  logic [SUM_BITS-1:0]     rsum_r;
  logic [LEN_BITS-1:0]     fill_r;
  logic [COUNT_BITS-1:0]   hit_r;
  logic                    out_valid_r;
  logic                    out_full_r;
  logic                    out_meets_r;

  logic [SUM_BITS-1:0]     rsum_nxt;
  logic [LEN_BITS-1:0]     fill_nxt;
  logic [COUNT_BITS-1:0]   hit_nxt;
  logic                    full_nxt;
  logic                    meets_nxt;

  logic                    in_acc;
  logic                    cfg_acc;
  logic [LEN_BITS-1:0]     len_eff;
  logic [SAMPLE_BITS-1:0]  sample;
  logic [SAMPLE_BITS-1:0]  old_sample;
  logic [SUM_BITS-1:0]     sum_base;
  logic [LEN_BITS-1:0]     fill_base;
  logic [COUNT_BITS-1:0]   hit_base;
  wstc_chain_ctl_t         chain_ctl;

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign len_eff   = eff_len(window_len_r);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = !cfg_hold_r && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign chain_ctl.shift  = in_acc;
  assign chain_ctl.len_m1 = IDX_BITS'(len_eff - LEN_BITS'(1));

  wstc_chain u_chain (
    .clk        (clk),
    .ctl        (chain_ctl),
    .sample     (sample),
    .old_sample (old_sample)
  );

  always_comb begin
    sum_base  = in_tuser ? '0 : rsum_r;
    fill_base = in_tuser ? '0 : fill_r;
    hit_base  = in_tuser ? '0 : hit_r;
    rsum_nxt  = sum_base + SUM_BITS'(sample);
    if (fill_base >= len_eff) begin
      rsum_nxt = rsum_nxt - SUM_BITS'(old_sample);
    end
    fill_nxt = (fill_base < LEN_BITS'(WINDOW_MAX)) ? fill_base + LEN_BITS'(1) : fill_base;
    full_nxt  = fill_nxt >= len_eff;
    meets_nxt = full_nxt && (THR_LEN_BITS'(rsum_nxt) >= thr_len_r);
    hit_nxt   = (meets_nxt && (hit_base != '1)) ? hit_base + COUNT_BITS'(1) : hit_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= CFG_LEN_BITS'(1);
      threshold_r  <= '0;
      thr_len_r    <= '0;
      cfg_hold_r   <= 1'b0;
      rsum_r       <= '0;
      fill_r       <= '0;
      hit_r        <= '0;
      out_valid_r  <= 1'b0;
      out_full_r   <= 1'b0;
      out_meets_r  <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_acc;
      thr_len_r  <= THR_LEN_BITS'(threshold_r) * THR_LEN_BITS'(len_eff);
      if (cfg_acc) begin
        case (cfg_index)
          CFG_IDX_WINDOW_LEN: window_len_r <= cfg_data[CFG_LEN_BITS-1:0];
          CFG_IDX_THRESHOLD:  threshold_r  <= cfg_data[CFG_THR_BITS-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        rsum_r      <= rsum_nxt;
        fill_r      <= fill_nxt;
        hit_r       <= hit_nxt;
        out_full_r  <= full_nxt;
        out_meets_r <= meets_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'({hit_r, out_meets_r, out_full_r});

  `WSTC_ASSERT_NOW(a_meets_needs_full, out_valid_r && out_meets_r, out_full_r,
    "window_meets set without a full window")
  `WSTC_ASSERT_NEXT(a_cfg_holds_input, cfg_acc, !in_tready,
    "input taken in the cycle after a configuration write")
  `WSTC_ASSERT_NOW(a_count_monotonic, in_acc && !in_tuser, hit_nxt >= hit_r,
    "match count fell within a sequence")
  `WSTC_ASSERT_NOW(a_fill_bounded, 1'b1, fill_r <= LEN_BITS'(WINDOW_MAX),
    "fill level beyond the window capacity")

endmodule

[sv/wstc_cell.sv]
module wstc_cell (
  input  logic                          clk,
  input  wstc_pkg::wstc_chain_ctl_t     ctl,
  input  logic [wstc_pkg::IDX_BITS-1:0] cell_idx,
  input  logic [wstc_pkg::SAMPLE_BITS-1:0] din,
  output logic [wstc_pkg::SAMPLE_BITS-1:0] dout,
  output logic [wstc_pkg::SAMPLE_BITS-1:0] tap
);
  import wstc_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] sample_nxt;

  assign sample_nxt = ctl.shift ? din : sample_r;
  assign dout       = sample_r;
  assign tap        = (cell_idx == ctl.len_m1) ? sample_nxt : '0;

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

endmodule

[sv/wstc_chain.sv]
module wstc_chain (
  input  logic                             clk,
  input  wstc_pkg::wstc_chain_ctl_t        ctl,
  input  logic [wstc_pkg::SAMPLE_BITS-1:0] sample,
  output logic [wstc_pkg::SAMPLE_BITS-1:0] old_sample
);
  import wstc_pkg::*;

  logic [SAMPLE_BITS-1:0] link [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] tap  [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] group_nxt [NUM_GROUPS];
  logic [SAMPLE_BITS-1:0] group_r   [NUM_GROUPS];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] din;
    if (i == 0) begin : g_head
      assign din = sample;
    end else begin : g_body
      assign din = link[i-1];
    end
    wstc_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IDX_BITS'(i)),
      .din      (din),
      .dout     (link[i]),
      .tap      (tap[i])
    );
  end

  // Each group register holds the tap of the cell that will sit len-1 places
  // back after this cycle's shift if that cell is in its group, else zero.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < WINDOW_MAX) begin
          group_nxt[g] = group_nxt[g] | tap[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_r[g] <= group_nxt[g];
    end
  end

  always_comb begin
    old_sample = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      old_sample = old_sample | group_r[g];
    end
  end

endmodule
